>>> rtl/thc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle clipper package
// Shared widths, plane codes, the divider chain control word and the small
// helpers that pick vertices and coordinates out of a stored triangle row.
// ----------------------------------------------------------------------------
package thc_pkg;

  localparam int COORD_W = 32;
  localparam int VTX_W   = 4 * COORD_W;
  localparam int ROW_W   = 3 * VTX_W;
  localparam int DIST_W  = COORD_W + 1;
  localparam int MAG_W   = DIST_W + 1;

  // Clip planes in the order they are applied.
  localparam logic [2:0] PLANE_LEFT   = 3'd0;
  localparam logic [2:0] PLANE_RIGHT  = 3'd1;
  localparam logic [2:0] PLANE_BOTTOM = 3'd2;
  localparam logic [2:0] PLANE_TOP    = 3'd3;
  localparam logic [2:0] PLANE_NEAR   = 3'd4;
  localparam logic [2:0] PLANE_FAR    = 3'd5;

  localparam logic [1:0] COORD_W_SEL = 2'd3;

  // Control word that travels alongside each division through the chain.
  typedef struct packed {
    logic valid;
    logic tag;
    logic force_low;
    logic force_high;
  } div_ctrl_t;

  function automatic logic [VTX_W-1:0] get_vtx(input logic [ROW_W-1:0] row,
                                               input logic [1:0] sel);
    logic [VTX_W-1:0] v;
    case (sel)
      2'd0:    v = row[0*VTX_W +: VTX_W];
      2'd1:    v = row[1*VTX_W +: VTX_W];
      default: v = row[2*VTX_W +: VTX_W];
    endcase
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] get_coord(input logic [VTX_W-1:0] v,
                                                   input logic [1:0] sel);
    logic [COORD_W-1:0] c;
    case (sel)
      2'd0:    c = v[0*COORD_W +: COORD_W];
      2'd1:    c = v[1*COORD_W +: COORD_W];
      2'd2:    c = v[2*COORD_W +: COORD_W];
      default: c = v[3*COORD_W +: COORD_W];
    endcase
    return c;
  endfunction

  // Signed distance of a vertex from a plane: w + c or w - c.
  function automatic logic signed [DIST_W-1:0] plane_dist(input logic [VTX_W-1:0] v,
                                                          input logic [2:0] plane);
    logic [COORD_W-1:0] c;
    logic [COORD_W-1:0] w;
    logic signed [DIST_W-1:0] d;
    c = get_coord(v, plane[2:1]);
    w = get_coord(v, COORD_W_SEL);
    if (plane[0]) begin
      d = $signed({w[COORD_W-1], w}) - $signed({c[COORD_W-1], c});
    end else begin
      d = $signed({w[COORD_W-1], w}) + $signed({c[COORD_W-1], c});
    end
    return d;
  endfunction

  // Next vertex index, modulo three.
  function automatic logic [1:0] rot3(input logic [1:0] k);
    return (k == 2'd2) ? 2'd0 : k + 2'd1;
  endfunction

  function automatic logic [63:0] pack_xy(input logic [VTX_W-1:0] v);
    return {get_coord(v, 2'd0), get_coord(v, 2'd1)};
  endfunction

  function automatic logic [63:0] pack_zw(input logic [VTX_W-1:0] v);
    return {get_coord(v, 2'd2), get_coord(v, COORD_W_SEL)};
  endfunction

endpackage

>>> rtl/homogeneous_triangle_clipper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Homogeneous triangle clipper
// Gathers three clip-space vertices per triangle, clips front-facing ones
// against the six frustum planes in a triangle store, streams out survivors.
// ----------------------------------------------------------------------------
// A vertex beat can be taken every cycle while idle. On the third beat of a
// front-facing triangle the input stalls while clipping runs: per plane, a
// dead store slot is skipped, a kept or culled slot is read and tested, and
// a cut slot also waits for the divider cell chain that yields the crossing
// scalars and for the one-multiplier interpolation of the eight cut
// coordinates. Survivors then leave through the single read port of the
// triangle store; the output register lets the next vertex beat in while
// the final result waits to be taken.
module homogeneous_triangle_clipper import thc_pkg::*; #(
  parameter int MAX_TRIANGLES   = 64,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_x_coord,
  input  logic [31:0] in_y_coord,
  input  logic [31:0] in_z_coord,
  input  logic [31:0] in_w_coord,
  input  logic        in_is_backface,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_v0_xy,
  output logic [63:0] out_v0_zw,
  output logic [63:0] out_v1_xy,
  output logic [63:0] out_v1_zw,
  output logic [63:0] out_v2_xy,
  output logic [63:0] out_v2_zw,
  output logic        out_last_triangle
);

  localparam int IDX_W  = $clog2(MAX_TRIANGLES);
  localparam int CNT_W  = $clog2(MAX_TRIANGLES + 1);
  localparam int PROD_W = DIST_W + COORD_FRAC_BITS + 1;

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b0000_0000_0001,
    ST_INIT    = 12'b0000_0000_0010,
    ST_NEXT    = 12'b0000_0000_0100,
    ST_READ    = 12'b0000_0000_1000,
    ST_TEST    = 12'b0000_0001_0000,
    ST_DIVB    = 12'b0000_0010_0000,
    ST_DIVW    = 12'b0000_0100_0000,
    ST_INTERP  = 12'b0000_1000_0000,
    ST_WR1     = 12'b0001_0000_0000,
    ST_WR2     = 12'b0010_0000_0000,
    ST_EMIT    = 12'b0100_0000_0000,
    ST_EMIT_RD = 12'b1000_0000_0000
  } state_t;

  state_t                     state_r;
  logic [1:0]                 phase_r;
  logic [VTX_W-1:0]           held_r [3];
  logic [MAX_TRIANGLES-1:0]   alive_r;
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           limit_r;
  logic [CNT_W-1:0]           idx_r;
  logic [2:0]                 plane_r;
  logic signed [DIST_W-1:0]   d_r [3];
  logic [1:0]                 k_r;
  logic                       split_r;
  logic [COORD_FRAC_BITS-1:0] s_a_r;
  logic [COORD_FRAC_BITS-1:0] s_b_r;
  logic [3:0]                 step_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic [COORD_W-1:0]         base_r;
  logic [COORD_W-1:0]         cut_r [8];
  logic                       out_valid_r;
  logic [63:0]                out_v0_xy_r;
  logic [63:0]                out_v0_zw_r;
  logic [63:0]                out_v1_xy_r;
  logic [63:0]                out_v1_zw_r;
  logic [63:0]                out_v2_xy_r;
  logic [63:0]                out_v2_zw_r;
  logic                       out_last_r;

  // Triangle store: one row of three vertices per slot.
  logic [ROW_W-1:0] tri_mem [MAX_TRIANGLES];
  logic [ROW_W-1:0] mem_q_r;
  logic             mem_we;
  logic             mem_re;
  logic [IDX_W-1:0] mem_wa;
  logic [ROW_W-1:0] mem_wd;

  logic                       in_acc;
  logic [1:0]                 slot;
  logic                       out_free;
  logic [IDX_W-1:0]           idx_lo;
  logic                       idx_end;
  logic                       emit_end;
  logic [2:0]                 ins;
  logic [1:0]                 ins_cnt;
  logic [1:0]                 k_comb;
  logic [1:0]                 kk;
  logic                       feed_valid;
  logic                       feed_tag;
  logic signed [DIST_W-1:0]   feed_d1;
  logic signed [DIST_W-1:0]   feed_d2;
  logic                       s_valid;
  logic                       s_tag;
  logic [COORD_FRAC_BITS-1:0] s_val;
  logic [VTX_W-1:0]           vk;
  logic [VTX_W-1:0]           vk1;
  logic [VTX_W-1:0]           vk2;
  logic [VTX_W-1:0]           n1;
  logic [VTX_W-1:0]           n2;
  logic [VTX_W-1:0]           end_b;
  logic [COORD_W-1:0]         a_c;
  logic [COORD_W-1:0]         b_c;
  logic signed [DIST_W-1:0]   diff;
  logic [COORD_FRAC_BITS-1:0] s_sel;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [PROD_W-1:0]   lerp;
  logic [2:0]                 cut_idx;
  logic                       last_nxt;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign slot     = (phase_r >= 2'd2) ? 2'd2 : phase_r;
  assign out_free = !out_valid_r || !out_stall;
  assign idx_lo   = idx_r[IDX_W-1:0];
  assign idx_end  = (idx_r == limit_r);
  assign emit_end = (idx_r == count_r);

  // Inside test and choice of the lone vertex of the triangle.
  always_comb begin
    ins[0]  = ~d_r[0][DIST_W-1];
    ins[1]  = ~d_r[1][DIST_W-1];
    ins[2]  = ~d_r[2][DIST_W-1];
    ins_cnt = {1'b0, ins[0]} + {1'b0, ins[1]} + {1'b0, ins[2]};
    if (ins_cnt == 2'd2) begin
      k_comb = !ins[0] ? 2'd0 : (!ins[1] ? 2'd1 : 2'd2);
    end else begin
      k_comb = ins[0] ? 2'd0 : (ins[1] ? 2'd1 : 2'd2);
    end
  end

  // Feed of the two crossings into the divider chain, in ST_TEST and ST_DIVB.
  always_comb begin
    kk         = (state_r == ST_TEST) ? k_comb : k_r;
    feed_valid = ((state_r == ST_TEST) && (ins_cnt == 2'd1 || ins_cnt == 2'd2)) ||
                 (state_r == ST_DIVB);
    feed_tag   = (state_r == ST_DIVB);
    feed_d1    = d_r[kk];
    feed_d2    = (state_r == ST_DIVB) ? d_r[rot3(rot3(kk))] : d_r[rot3(kk)];
  end

  thc_scalar_chain #(
    .FRAC_BITS(COORD_FRAC_BITS)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .feed_valid(feed_valid),
    .feed_tag  (feed_tag),
    .feed_d1   (feed_d1),
    .feed_d2   (feed_d2),
    .s_valid   (s_valid),
    .s_tag     (s_tag),
    .s_val     (s_val)
  );

  // Interpolation: a + floor((b - a) * s / 2^F), one coordinate per cycle.
  always_comb begin
    vk       = get_vtx(mem_q_r, k_r);
    vk1      = get_vtx(mem_q_r, rot3(k_r));
    vk2      = get_vtx(mem_q_r, rot3(rot3(k_r)));
    n1       = {cut_r[3], cut_r[2], cut_r[1], cut_r[0]};
    n2       = {cut_r[7], cut_r[6], cut_r[5], cut_r[4]};
    end_b    = step_r[2] ? vk2 : vk1;
    a_c      = get_coord(vk, step_r[1:0]);
    b_c      = get_coord(end_b, step_r[1:0]);
    diff     = $signed({b_c[COORD_W-1], b_c}) - $signed({a_c[COORD_W-1], a_c});
    s_sel    = step_r[2] ? s_b_r : s_a_r;
    prod_nxt = PROD_W'(diff) * PROD_W'($signed({1'b0, s_sel}));
    lerp     = PROD_W'($signed(base_r)) + (prod_r >>> COORD_FRAC_BITS);
    cut_idx  = 3'(step_r - 4'd1);
    last_nxt = (((alive_r >> idx_r) >> 1) == '0);
  end

  // Store port control.
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = idx_lo;
    mem_wd = {held_r[2], held_r[1], held_r[0]};
    unique case (state_r)
      ST_INIT: begin
        mem_we = 1'b1;
        mem_wa = '0;
      end
      ST_NEXT: begin
        mem_re = !idx_end && alive_r[idx_lo];
      end
      ST_WR1: begin
        mem_we = 1'b1;
        mem_wd = split_r ? {n1, vk2, vk1} : {n2, n1, vk};
      end
      ST_WR2: begin
        mem_we = 1'b1;
        mem_wa = count_r[IDX_W-1:0];
        mem_wd = {n2, vk2, n1};
      end
      ST_EMIT: begin
        mem_re = !emit_end && alive_r[idx_lo] && out_free;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tri_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= tri_mem[idx_lo];
    end
  end

  // Sequencer over planes and store slots.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      alive_r     <= '0;
      count_r     <= '0;
      limit_r     <= '0;
      idx_r       <= '0;
      plane_r     <= PLANE_LEFT;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_EMIT_RD)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (slot != 2'd2) begin
              phase_r <= slot + 2'd1;
            end else begin
              phase_r <= '0;
              if (!in_is_backface) begin
                state_r <= ST_INIT;
              end
            end
          end
        end
        ST_INIT: begin
          alive_r    <= MAX_TRIANGLES'(1);
          count_r    <= CNT_W'(1);
          limit_r    <= CNT_W'(1);
          idx_r      <= '0;
          plane_r    <= PLANE_LEFT;
          state_r    <= ST_NEXT;
        end
        ST_NEXT: begin
          if (idx_end) begin
            idx_r <= '0;
            if (plane_r == PLANE_FAR) begin
              state_r <= ST_EMIT;
            end else begin
              plane_r <= plane_r + 3'd1;
              limit_r <= count_r;
            end
          end else if (!alive_r[idx_lo]) begin
            idx_r <= idx_r + CNT_W'(1);
          end else begin
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_TEST;
        end
        ST_TEST: begin
          if (ins_cnt == 2'd0) begin
            alive_r[idx_lo] <= 1'b0;
            idx_r           <= idx_r + CNT_W'(1);
            state_r         <= ST_NEXT;
          end else if (ins_cnt == 2'd3) begin
            idx_r   <= idx_r + CNT_W'(1);
            state_r <= ST_NEXT;
          end else begin
            state_r <= ST_DIVB;
          end
        end
        ST_DIVB: begin
          state_r <= ST_DIVW;
        end
        ST_DIVW: begin
          if (s_valid && s_tag) begin
            step_r  <= '0;
            state_r <= ST_INTERP;
          end
        end
        ST_INTERP: begin
          step_r <= step_r + 4'd1;
          if (step_r == 4'd8) begin
            state_r <= ST_WR1;
          end
        end
        ST_WR1: begin
          if (split_r && (count_r < CNT_W'(MAX_TRIANGLES))) begin
            state_r <= ST_WR2;
          end else begin
            idx_r   <= idx_r + CNT_W'(1);
            state_r <= ST_NEXT;
          end
        end
        ST_WR2: begin
          alive_r[count_r[IDX_W-1:0]] <= 1'b1;
          count_r <= count_r + CNT_W'(1);
          idx_r   <= idx_r + CNT_W'(1);
          state_r <= ST_NEXT;
        end
        ST_EMIT: begin
          if (emit_end) begin
            state_r <= ST_IDLE;
          end else if (!alive_r[idx_lo]) begin
            idx_r <= idx_r + CNT_W'(1);
          end else if (out_free) begin
            state_r <= ST_EMIT_RD;
          end
        end
        ST_EMIT_RD: begin
          out_valid_r <= 1'b1;
          idx_r       <= idx_r + CNT_W'(1);
          state_r     <= ST_EMIT;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: held and cut vertices, distances, scalars and outputs.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      held_r[slot] <= {in_w_coord, in_z_coord, in_y_coord, in_x_coord};
    end
    if (state_r == ST_READ) begin
      d_r[0] <= plane_dist(get_vtx(mem_q_r, 2'd0), plane_r);
      d_r[1] <= plane_dist(get_vtx(mem_q_r, 2'd1), plane_r);
      d_r[2] <= plane_dist(get_vtx(mem_q_r, 2'd2), plane_r);
    end
    if (state_r == ST_TEST) begin
      k_r     <= k_comb;
      split_r <= (ins_cnt == 2'd2);
    end
    if (s_valid) begin
      if (s_tag) begin
        s_b_r <= s_val;
      end else begin
        s_a_r <= s_val;
      end
    end
    if (state_r == ST_INTERP) begin
      prod_r <= prod_nxt;
      base_r <= a_c;
      if (step_r != 4'd0) begin
        cut_r[cut_idx] <= lerp[COORD_W-1:0];
      end
    end
    if (state_r == ST_EMIT_RD) begin
      out_v0_xy_r <= pack_xy(get_vtx(mem_q_r, 2'd0));
      out_v0_zw_r <= pack_zw(get_vtx(mem_q_r, 2'd0));
      out_v1_xy_r <= pack_xy(get_vtx(mem_q_r, 2'd1));
      out_v1_zw_r <= pack_zw(get_vtx(mem_q_r, 2'd1));
      out_v2_xy_r <= pack_xy(get_vtx(mem_q_r, 2'd2));
      out_v2_zw_r <= pack_zw(get_vtx(mem_q_r, 2'd2));
      out_last_r  <= last_nxt;
    end
  end

  // Result beat.
  assign out_valid         = out_valid_r;
  assign out_v0_xy         = out_v0_xy_r;
  assign out_v0_zw         = out_v0_zw_r;
  assign out_v1_xy         = out_v1_xy_r;
  assign out_v1_zw         = out_v1_zw_r;
  assign out_v2_xy         = out_v2_xy_r;
  assign out_v2_zw         = out_v2_zw_r;
  assign out_last_triangle = out_last_r;

endmodule

>>> rtl/thc_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: doubles the partial remainder, subtracts the
// divisor where it fits and shifts one quotient bit in, then hands the lot on.
// ----------------------------------------------------------------------------
module thc_div_cell import thc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  div_ctrl_t            ctrl_i,
  input  logic [MAG_W-1:0]     rem_i,
  input  logic [MAG_W-1:0]     den_i,
  input  logic [FRAC_BITS-1:0] quo_i,
  output div_ctrl_t            ctrl_o,
  output logic [MAG_W-1:0]     rem_o,
  output logic [MAG_W-1:0]     den_o,
  output logic [FRAC_BITS-1:0] quo_o
);

  logic [MAG_W:0] shifted;
  logic [MAG_W:0] diff;
  logic           fits;

  // Trial subtraction of the divisor from the doubled remainder.
  assign shifted = {rem_i, 1'b0};
  assign diff    = shifted - {1'b0, den_i};
  assign fits    = (shifted >= {1'b0, den_i});

  // Control travels with the data and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_o <= '0;
    end else begin
      ctrl_o <= ctrl_i;
    end
  end

  // Datapath registers of this step.
  always_ff @(posedge clk) begin
    rem_o <= fits ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
    den_o <= den_i;
    quo_o <= {quo_i[FRAC_BITS-2:0], fits};
  end

endmodule

>>> rtl/thc_scalar_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crossing scalar chain
// Works out s = d1 * 2^F / (d1 - d2) for one plane crossing as a row of
// divider cells, one quotient bit per cell, and applies the clamping rules.
// ----------------------------------------------------------------------------
module thc_scalar_chain import thc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     feed_valid,
  input  logic                     feed_tag,
  input  logic signed [DIST_W-1:0] feed_d1,
  input  logic signed [DIST_W-1:0] feed_d2,
  output logic                     s_valid,
  output logic                     s_tag,
  output logic [FRAC_BITS-1:0]     s_val
);

  logic signed [MAG_W-1:0] num;
  logic signed [MAG_W-1:0] den_raw;
  logic signed [MAG_W-1:0] den;
  logic [MAG_W-1:0]        num_mag;
  logic [MAG_W-1:0]        den_mag;
  logic                    low;
  logic                    high;

  div_ctrl_t              ctrl [FRAC_BITS+1];
  logic [MAG_W-1:0]       rem  [FRAC_BITS+1];
  logic [MAG_W-1:0]       dvs  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0]   quo  [FRAC_BITS+1];

  logic [FRAC_BITS-1:0]   q_last;

  // Operand preparation: a zero divisor becomes one, and a quotient that is
  // negative, zero or at least one is settled here without dividing.
  always_comb begin
    num     = {feed_d1[DIST_W-1], feed_d1};
    den_raw = num - $signed({feed_d2[DIST_W-1], feed_d2});
    den     = (den_raw == '0) ? MAG_W'(1) : den_raw;
    num_mag = num[MAG_W-1] ? MAG_W'(-num) : MAG_W'(num);
    den_mag = den[MAG_W-1] ? MAG_W'(-den) : MAG_W'(den);
    low     = (num == '0) || (num[MAG_W-1] != den[MAG_W-1]);
    high    = !low && (num_mag >= den_mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl[0] <= '0;
    end else begin
      ctrl[0] <= '{valid: feed_valid, tag: feed_tag, force_low: low,
                   force_high: high};
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= num_mag;
    dvs[0] <= den_mag;
    quo[0] <= '0;
  end

  // The row of cells, one quotient bit each.
  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
    thc_div_cell #(
      .FRAC_BITS(FRAC_BITS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl_i(ctrl[i]),
      .rem_i (rem[i]),
      .den_i (dvs[i]),
      .quo_i (quo[i]),
      .ctrl_o(ctrl[i+1]),
      .rem_o (rem[i+1]),
      .den_o (dvs[i+1]),
      .quo_o (quo[i+1])
    );
  end

  // Clamp: never exactly zero and never exactly one.
  assign q_last = quo[FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= ctrl[FRAC_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    s_tag <= ctrl[FRAC_BITS].tag;
    if (ctrl[FRAC_BITS].force_low || (!ctrl[FRAC_BITS].force_high && q_last == '0)) begin
      s_val <= FRAC_BITS'(1);
    end else if (ctrl[FRAC_BITS].force_high) begin
      s_val <= '1;
    end else begin
      s_val <= q_last;
    end
  end

endmodule

>>> verif/homogeneous_triangle_clipper_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Homogeneous triangle clipper testbench
// Drives vertex beats into the clipper and checks every output triangle
// against a fixed point clipping predictor. A directed table comes first,
// then random triangles, with random idling on both channels but in one stretch.
// ----------------------------------------------------------------------------
module homogeneous_triangle_clipper_test;

  localparam int FRAC     = 16;
  localparam int MAX_TRI  = 64;
  localparam int WATCHDOG = 200000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic        bf;
  } vtx_beat_t;

  typedef struct packed {
    logic [63:0] v0_xy;
    logic [63:0] v0_zw;
    logic [63:0] v1_xy;
    logic [63:0] v1_zw;
    logic [63:0] v2_xy;
    logic [63:0] v2_zw;
    logic        last;
  } tri_beat_t;

  // The fully inside directed triangle leaves exactly as it went in.
  localparam tri_beat_t INSIDE_TRI = '{
    v0_xy: 64'h0000_0000_0000_0000,
    v0_zw: 64'h0000_0000_0001_0000,
    v1_xy: 64'h0000_8000_0000_0000,
    v1_zw: 64'h0000_0000_0001_0000,
    v2_xy: 64'h0000_0000_0000_8000,
    v2_zw: 64'h0000_0000_0001_0000,
    last:  1'b1
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_x_coord;
  logic [31:0] in_y_coord;
  logic [31:0] in_z_coord;
  logic [31:0] in_w_coord;
  logic        in_is_backface;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_v0_xy;
  logic [63:0] out_v0_zw;
  logic [63:0] out_v1_xy;
  logic [63:0] out_v1_zw;
  logic [63:0] out_v2_xy;
  logic [63:0] out_v2_zw;
  logic        out_last_triangle;

  homogeneous_triangle_clipper dut (.*);

  // Predictor state.
  logic [31:0] pend_vtx [3][4];
  int          pend_phase;
  longint      tri_v [MAX_TRI][3][4];
  bit          tri_live [MAX_TRI];
  int          tri_n;

  tri_beat_t   expected_tris[$];
  vtx_beat_t   stim[$];
  int          errors;
  int          n_results;
  int          n_splits_seen;
  bit          quiet;      // no idling on either side
  int          idle_pct;
  int          stall_until_empty;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint sx(input logic [31:0] u);
    return longint'($signed(u));
  endfunction

  function automatic longint dist_of(input longint c[4], input int p);
    longint a;
    a = c[(p >> 1) & 3];
    return (p & 1) ? c[3] - a : c[3] + a;
  endfunction

  function automatic longint crossing(input longint a[4], input longint b[4], input int p);
    longint num;
    longint den;
    longint s;
    longint one;
    one = longint'(1) << FRAC;
    num = dist_of(a, p);
    den = num - dist_of(b, p);
    if (den == 0) den = 1;
    s = (num * one) / den;
    if (s < 0) s = 0;
    if (s > one) s = one;
    if (s == 0) s = 1;
    if (s == one) s = one - 1;
    return s;
  endfunction

  // Point on the edge a-b where it crosses plane p, wrapped to 32 bits.
  task automatic edge_cut(input longint a[4], input longint b[4], input int p,
                          output longint o[4]);
    longint s;
    longint t;
    longint one;
    one = longint'(1) << FRAC;
    s = crossing(a, b, p);
    for (int k = 0; k < 4; k++) begin
      t = a[k] * (one - s) + b[k] * s;
      if (t >= 0) t = t / one;
      else t = -((-t + one - 1) / one);
      o[k] = sx(t[31:0]);
    end
  endtask

  task automatic put_tri(input int t, input longint a[4], input longint b[4],
                         input longint c[4]);
    for (int j = 0; j < 4; j++) begin
      tri_v[t][0][j] = a[j];
      tri_v[t][1][j] = b[j];
      tri_v[t][2][j] = c[j];
    end
  endtask

  // Clip one front-facing triangle and queue the survivors.
  task automatic clip_triangle();
    longint v[3][4];
    longint n1[4];
    longint n2[4];
    bit     ins[3];
    int     cnt;
    int     k;
    int     n;
    int     last;
    tri_beat_t r;
    for (int i = 0; i < MAX_TRI; i++) tri_live[i] = 0;
    for (int a = 0; a < 3; a++)
      for (int c = 0; c < 4; c++) tri_v[0][a][c] = sx(pend_vtx[a][c]);
    tri_live[0] = 1;
    tri_n = 1;
    for (int p = 0; p < 6; p++) begin
      n = tri_n;
      for (int i = 0; i < n; i++) begin
        if (!tri_live[i]) continue;
        v = tri_v[i];
        cnt = 0;
        for (int a = 0; a < 3; a++) begin
          ins[a] = dist_of(v[a], p) >= 0;
          cnt += ins[a];
        end
        if (cnt == 0) begin
          tri_live[i] = 0;
        end else if (cnt == 1) begin
          k = ins[0] ? 0 : (ins[1] ? 1 : 2);
          edge_cut(v[k], v[(k + 1) % 3], p, n1);
          edge_cut(v[k], v[(k + 2) % 3], p, n2);
          put_tri(i, v[k], n1, n2);
        end else if (cnt == 2) begin
          k = !ins[0] ? 0 : (!ins[1] ? 1 : 2);
          edge_cut(v[k], v[(k + 1) % 3], p, n1);
          edge_cut(v[k], v[(k + 2) % 3], p, n2);
          put_tri(i, v[(k + 1) % 3], v[(k + 2) % 3], n1);
          if (tri_n < MAX_TRI) begin
            put_tri(tri_n, n1, v[(k + 2) % 3], n2);
            tri_live[tri_n] = 1;
            tri_n++;
            n_splits_seen++;
          end
        end
      end
    end
    last = -1;
    for (int i = 0; i < tri_n; i++) if (tri_live[i]) last = i;
    for (int i = 0; i < tri_n; i++) begin
      if (!tri_live[i]) continue;
      r.v0_xy = {tri_v[i][0][0][31:0], tri_v[i][0][1][31:0]};
      r.v0_zw = {tri_v[i][0][2][31:0], tri_v[i][0][3][31:0]};
      r.v1_xy = {tri_v[i][1][0][31:0], tri_v[i][1][1][31:0]};
      r.v1_zw = {tri_v[i][1][2][31:0], tri_v[i][1][3][31:0]};
      r.v2_xy = {tri_v[i][2][0][31:0], tri_v[i][2][1][31:0]};
      r.v2_zw = {tri_v[i][2][2][31:0], tri_v[i][2][3][31:0]};
      r.last  = (i == last);
      expected_tris = {expected_tris, r};
    end
  endtask

  // Advance the predictor by one accepted vertex beat.
  task automatic predict_vertex(input vtx_beat_t b);
    pend_vtx[pend_phase][0] = b.x;
    pend_vtx[pend_phase][1] = b.y;
    pend_vtx[pend_phase][2] = b.z;
    pend_vtx[pend_phase][3] = b.w;
    if (pend_phase < 2) begin
      pend_phase++;
    end else begin
      pend_phase = 0;
      if (!b.bf) clip_triangle();
    end
  endtask

  task automatic report(input string what, input logic [63:0] got,
                        input logic [63:0] want);
    errors++;
    if (errors <= 40)
      $display("result %0d %s: got %h want %h", n_results, what, got, want);
  endtask

  function automatic logic [31:0] fx(input int v);
    return 32'(v) << FRAC;
  endfunction

  function automatic vtx_beat_t mk(input logic [31:0] x, input logic [31:0] y,
                                   input logic [31:0] z, input logic [31:0] w,
                                   input logic bf);
    vtx_beat_t b;
    b.x = x; b.y = y; b.z = z; b.w = w; b.bf = bf;
    return b;
  endfunction

  // Random coordinate: mostly near the frustum, sometimes any 32-bit value.
  function automatic logic [31:0] rnd_coord(input logic [31:0] w);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom;
    if (sel == 1) return $signed(w) * ($urandom_range(0, 1) ? 1 : -1);
    return $signed($urandom_range(0, 6 << FRAC)) - (3 << FRAC);
  endfunction

  task automatic add_random_triangle();
    logic [31:0] w;
    for (int a = 0; a < 3; a++) begin
      if ($urandom_range(0, 19) == 0) w = $urandom;
      else w = $urandom_range(1 << (FRAC - 4), 4 << FRAC);
      stim = {stim, mk(rnd_coord(w), rnd_coord(w), rnd_coord(w), w,
                       (a == 2) ? ($urandom_range(0, 7) == 0) :
                                  1'($urandom_range(0, 1)))};
    end
  endtask

  // Directed table: a triangle that is fully inside passes unchanged.
  localparam int N_DIR = 24;
  vtx_beat_t dir_tab [N_DIR];
  initial begin
    dir_tab[0]  = mk(fx(0), fx(0), fx(0), fx(1), 1'b1);
    dir_tab[1]  = mk(32'h0000_8000, fx(0), fx(0), fx(1), 1'b1);
    dir_tab[2]  = mk(fx(0), 32'h0000_8000, fx(0), fx(1), 1'b0);
    // Backfacing: nothing out.
    dir_tab[3]  = mk(fx(0), fx(0), fx(0), fx(1), 1'b0);
    dir_tab[4]  = mk(fx(0), fx(0), fx(0), fx(1), 1'b0);
    dir_tab[5]  = mk(fx(0), fx(0), fx(0), fx(1), 1'b1);
    // Fully outside the left plane.
    dir_tab[6]  = mk(fx(-5), fx(0), fx(0), fx(1), 1'b0);
    dir_tab[7]  = mk(fx(-6), fx(0), fx(0), fx(1), 1'b0);
    dir_tab[8]  = mk(fx(-7), fx(1), fx(0), fx(1), 1'b0);
    // One vertex beyond the right plane, one beyond the top: the triangle is cut.
    dir_tab[9]  = mk(fx(0), fx(0), fx(0), fx(1), 1'b0);
    dir_tab[10] = mk(fx(3), fx(0), fx(0), fx(1), 1'b0);
    dir_tab[11] = mk(fx(0), fx(3), fx(0), fx(1), 1'b0);
    // Two inside against the near plane: the triangle splits.
    dir_tab[12] = mk(fx(0), fx(0), fx(0), fx(1), 1'b0);
    dir_tab[13] = mk(32'h0000_4000, fx(0), fx(0), fx(1), 1'b0);
    dir_tab[14] = mk(fx(0), fx(0), fx(-4), fx(1), 1'b0);
    // Extremes of the coordinates, with zero denominators on edges in a plane.
    dir_tab[15] = mk(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    dir_tab[16] = mk(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b0);
    dir_tab[17] = mk(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 1'b0);
    dir_tab[18] = mk(fx(1), fx(1), fx(1), fx(1), 1'b0);
    dir_tab[19] = mk(fx(-1), fx(-1), fx(-1), fx(1), 1'b0);
    dir_tab[20] = mk(fx(1), fx(-1), fx(0), 32'h0, 1'b0);
    // A big triangle cut by all six planes.
    dir_tab[21] = mk(fx(-9), fx(-9), fx(-9), fx(1), 1'b0);
    dir_tab[22] = mk(fx(9), fx(-9), fx(9), fx(1), 1'b0);
    dir_tab[23] = mk(fx(0), fx(9), fx(0), fx(1), 1'b0);
  end

  // Sender: walks the stimulus queue.
  int sent;
  vtx_beat_t cur;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_x_coord     <= '0;
      in_y_coord     <= '0;
      in_z_coord     <= '0;
      in_w_coord     <= '0;
      in_is_backface <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_vertex(cur);
        sent++;
      end
      if (!in_valid || !in_stall) begin
        if (stim.size() > 0 && !(sent == stall_until_empty && expected_tris.size() > 0)
            && (quiet || $urandom_range(0, 99) >= idle_pct)) begin
          cur = stim.pop_front();
          in_valid       <= 1'b1;
          in_x_coord     <= cur.x;
          in_y_coord     <= cur.y;
          in_z_coord     <= cur.z;
          in_w_coord     <= cur.w;
          in_is_backface <= cur.bf;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall and field-by-field check.
  tri_beat_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_tris.size() == 0) begin
          report("unexpected", out_v0_xy, 64'h0);
        end else begin
          want = expected_tris.pop_front();
          if (out_v0_xy !== want.v0_xy) report("v0_xy", out_v0_xy, want.v0_xy);
          if (out_v0_zw !== want.v0_zw) report("v0_zw", out_v0_zw, want.v0_zw);
          if (out_v1_xy !== want.v1_xy) report("v1_xy", out_v1_xy, want.v1_xy);
          if (out_v1_zw !== want.v1_zw) report("v1_zw", out_v1_zw, want.v1_zw);
          if (out_v2_xy !== want.v2_xy) report("v2_xy", out_v2_xy, want.v2_xy);
          if (out_v2_zw !== want.v2_zw) report("v2_zw", out_v2_zw, want.v2_zw);
          if (out_last_triangle !== want.last)
            report("last_triangle", 64'(out_last_triangle), 64'(want.last));
        end
        // The first result is the fully inside directed triangle.
        if (n_results == 1 &&
            {out_v0_xy, out_v0_zw, out_v1_xy, out_v1_zw, out_v2_xy, out_v2_zw,
             out_last_triangle} !== INSIDE_TRI)
          report("inside triangle", out_v1_xy, INSIDE_TRI.v1_xy);
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < idle_pct);
    end
  end

  // Watchdog on cycles without any accepted beat.
  int dead_cycles;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) dead_cycles <= 0;
    else dead_cycles <= dead_cycles + 1;
    if (dead_cycles >= WATCHDOG) begin
      $display("watchdog expired with %0d results outstanding", expected_tris.size());
      $display("homogeneous_triangle_clipper: mismatch");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    rst_n = 1'b0;
    quiet = 0;
    idle_pct = 36;
    stall_until_empty = -1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows; the fully inside one is also checked by hand above.
    for (int i = 0; i < N_DIR; i++) stim = {stim, dir_tab[i]};
    // Sender waits for the outputs of the directed part to drain.
    stall_until_empty = N_DIR;
    for (int t = 0; t < 60; t++) add_random_triangle();
    wait (stim.size() == 0);
    // A stretch with no idling at all.
    quiet = 1;
    for (int t = 0; t < 30; t++) add_random_triangle();
    wait (stim.size() == 0);
    quiet = 0;
    for (int t = 0; t < 19; t++) add_random_triangle();
    wait (stim.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    wait (expected_tris.size() == 0);
    repeat (400) @(posedge clk);

    $display("%0d vertex beats sent, %0d triangles checked, %0d splits predicted",
             sent, n_results, n_splits_seen);
    if (errors == 0 && expected_tris.size() == 0) begin
      $display("homogeneous_triangle_clipper: match");
    end else begin
      $display("homogeneous_triangle_clipper: mismatch");
    end
    $finish;
  end

endmodule
